FILE: hw/rtl/bia_pkg.sv
// Shared constants and types of the bitmap id allocator.
package bia_pkg;

   localparam int CAPACITY   = 256;
   localparam int ID_W       = 9;
   localparam int ELEM_W     = 16;
   localparam int OFFSET_W   = 24;
   localparam int CSR_W      = 16;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int GROUP_W    = 32;
   localparam int GRP_BITS   = $clog2(GROUP_W);
   localparam int NUM_GROUPS = CAPACITY / GROUP_W;
   localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   localparam logic [ID_W-1:0] CAP_ID = ID_W'(CAPACITY);

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_QUERY   = 2'd2
   } bia_cmd_type;

   typedef enum logic {
      CSR_ELEM_BYTES  = 1'b0,
      CSR_MAX_ENTRIES = 1'b1
   } bia_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOOKUP,
      ST_MUL
   } bia_state_type;

   typedef struct packed {
      logic                en;
      logic [GIDX_W-1:0]   group;
      logic [GROUP_W-1:0]  word;
   } bia_wr_type;

endpackage

FILE: hw/rtl/bia_req_if.sv
// Request channel: command and slot id.
interface bia_req_if;
   import bia_pkg::*;
   logic            valid;
   logic            ready;
   logic [1:0]      command;
   logic [ID_W-1:0] id;
   modport source (output valid, output command, output id, input ready);
   modport sink   (input valid, input command, input id, output ready);
endinterface

FILE: hw/rtl/bia_rsp_if.sv
// Response channel: status, slot id and byte offset.
interface bia_rsp_if;
   import bia_pkg::*;
   logic                valid;
   logic                ready;
   logic                ok;
   logic [ID_W-1:0]     out_id;
   logic [OFFSET_W-1:0] offset;
   modport source (output valid, output ok, output out_id, output offset, input ready);
   modport sink   (input valid, input ok, input out_id, input offset, output ready);
endinterface

FILE: hw/rtl/bia_bitmap.sv
// Used-bit bitmap, organized as words of one group each, cleared at reset.
module bia_bitmap (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bia_pkg::GIDX_W-1:0]   rd_group,
   output logic [bia_pkg::GROUP_W-1:0]  rd_word,
   input  bia_pkg::bia_wr_type          wr
);
   import bia_pkg::*;

   logic [NUM_GROUPS-1:0][GROUP_W-1:0] words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
      end else if (wr.en) begin
         words_ff[wr.group] <= wr.word;
      end
   end

   assign rd_word = words_ff[rd_group];

endmodule

FILE: hw/rtl/bitmap_id_allocator.sv
// Top level of the first-fit bitmap id allocator.
// Slot ids count from 1 up to the smaller of max_entries and 256. Allocate
// scans the bitmap one 32-slot group per cycle from the bottom, claims the
// lowest free id, and returns it with its byte offset (id-1)*elem_bytes;
// when no id up to the limit is free it returns ok 0, id 0, offset 0.
// Release clears the bit of a valid id (ok 1 even if it was free); query
// returns ok 1 only for a valid id that is in use. Both echo the request id,
// and an id of 0 or above the limit gets ok 0 and offset 0. The block takes
// one request at a time: release and query pass through a lookup step and
// a multiply step before the next ready; allocate scans 1 to 8 groups, until
// it finds a free slot or passes the limit, and then takes the multiply step.
// The scan uses the shared group read port; the offset comes from one 8x16
// multiply in the final step. The response sits in an output register; if it
// has not been taken, the finished request holds in its last step until it
// has. The bitmap comes out of reset all free; elem_bytes resets to 1 and
// max_entries to 256. Write the registers only while idle.
module bitmap_id_allocator (
   input  logic                        clock,
   input  logic                        reset,
   bia_req_if.sink                     req,
   bia_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [bia_pkg::CSR_W-1:0]   csr_wdata
);
   import bia_pkg::*;

   // configuration registers
   logic [ELEM_W-1:0] elem_bytes_ff;
   logic [ID_W-1:0]   max_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_bytes_ff  <= ELEM_W'(1);
         max_entries_ff <= CAP_ID;
      end else if (csr_we) begin
         case (bia_csr_type'(csr_index))
            CSR_ELEM_BYTES:  elem_bytes_ff  <= csr_wdata[ELEM_W-1:0];
            CSR_MAX_ENTRIES: max_entries_ff <= csr_wdata[ID_W-1:0];
            default: ;
         endcase
      end
   end

   // effective limit: highest id that may be handed out or addressed
   logic [ID_W-1:0] lim;
   assign lim = (max_entries_ff < CAP_ID) ? max_entries_ff : CAP_ID;

   // sequencer state and working registers
   bia_state_type     state_ff, state_in;
   bia_cmd_type       cmd_ff, cmd_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [GIDX_W-1:0] group_ff, group_in;
   logic              ok_ff, ok_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   // bitmap access
   logic [GIDX_W-1:0]  rd_group;
   logic [GROUP_W-1:0] rd_word;
   bia_wr_type         wr;

   bia_bitmap u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .rd_group (rd_group),
      .rd_word  (rd_word),
      .wr       (wr)
   );

   // scan helpers: free slots of the current group below the limit
   logic [GROUP_W-1:0]  free_mask;
   logic                free_found;
   logic [GRP_BITS-1:0] free_pos;
   logic [SLOT_W:0]     next_base;
   logic                id_ok;
   logic [GRP_BITS-1:0] lk_pos;
   logic [OFFSET_W-1:0] product;
   logic                out_free;

   always_comb begin
      for (int b = 0; b < GROUP_W; b++) begin
         free_mask[b] = !rd_word[b] &&
            ({1'b0, group_ff, GRP_BITS'(b)} < (SLOT_W + 1)'(lim));
      end
   end

   // lowest free bit of the group
   always_comb begin
      free_found = 1'b0;
      free_pos   = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
         if (free_mask[b]) begin
            free_found = 1'b1;
            free_pos   = GRP_BITS'(b);
         end
      end
   end

   assign next_base = {1'b0, group_ff, {GRP_BITS{1'b0}}} + (SLOT_W + 1)'(GROUP_W);
   assign id_ok     = (id_ff != '0) && (id_ff <= lim);
   assign lk_pos    = slot_ff[GRP_BITS-1:0];
   assign product   = OFFSET_W'(slot_ff) * OFFSET_W'(elem_bytes_ff);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign rd_group  = (state_ff == ST_SCAN) ? group_ff : slot_ff[SLOT_W-1 -: GIDX_W];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      slot_in       = slot_ff;
      group_in      = group_ff;
      ok_in         = ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_offset_in = rsp_offset_ff;
      wr            = '{en: 1'b0, group: rd_group, word: rd_word};

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd_in   = bia_cmd_type'(req.command);
               id_in    = req.id;
               slot_in  = SLOT_W'(req.id - ID_W'(1));
               group_in = '0;
               ok_in    = 1'b0;
               case (bia_cmd_type'(req.command))
                  CMD_ALLOC:   state_in = ST_SCAN;
                  CMD_RELEASE,
                  CMD_QUERY:   state_in = ST_LOOKUP;
                  default: begin
                     // unused command: answer all zero
                     id_in    = '0;
                     state_in = ST_MUL;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (free_found) begin
               // claim the slot
               wr.en    = 1'b1;
               wr.word  = rd_word | (GROUP_W'(1) << free_pos);
               slot_in  = {group_ff, free_pos};
               id_in    = ID_W'({group_ff, free_pos}) + ID_W'(1);
               ok_in    = 1'b1;
               state_in = ST_MUL;
            end else if (next_base >= (SLOT_W + 1)'(lim)) begin
               // passed the limit: table full
               id_in    = '0;
               ok_in    = 1'b0;
               state_in = ST_MUL;
            end else begin
               group_in = group_ff + GIDX_W'(1);
            end
         end

         ST_LOOKUP: begin
            if (cmd_ff == CMD_RELEASE) begin
               ok_in = id_ok;
               if (id_ok) begin
                  wr.en   = 1'b1;
                  wr.word = rd_word & ~(GROUP_W'(1) << lk_pos);
               end
            end else begin
               ok_in = id_ok && rd_word[lk_pos];
            end
            state_in = ST_MUL;
         end

         ST_MUL: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = ok_ff;
               rsp_id_in     = id_ff;
               rsp_offset_in = ok_ff ? product : '0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      slot_ff       <= slot_in;
      group_ff      <= group_in;
      ok_ff         <= ok_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign req.ready  = (state_ff == ST_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.ok     = rsp_ok_ff;
   assign rsp.out_id = rsp_id_ff;
   assign rsp.offset = rsp_offset_ff;

   // a successful response always names a real slot within the limit
   a_ok_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_id_ff != '0)
      else $error("ok response with id zero");

   a_ok_id_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ok_ff |-> rsp_id_ff <= lim)
      else $error("ok response with id above limit");

   a_fail_zero_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_offset_ff == '0)
      else $error("failed response with nonzero offset");

   a_rsp_from_mul: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_MUL)
      else $error("response raised outside final step");

   a_bitmap_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> state_ff == ST_SCAN || state_ff == ST_LOOKUP)
      else $error("bitmap written while not working on a request");

endmodule

FILE: tb/sv/bitmap_id_allocator_tb.sv
// Self-checking testbench of the bitmap id allocator: directed and random slot commands.
`timescale 1ns / 100ps

module bitmap_id_allocator_tb;
   import bia_pkg::*;

   // Command code the block does not define; it must leave state alone and answer all zero.
   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   // Cycles to let the block fall back to idle after its last reply.
   localparam int         SETTLE_CYCLES = 8;
   localparam int         ID_MAX        = CAPACITY;

   typedef struct {
      logic [1:0]      command;
      logic [ID_W-1:0] id;
      bit              drain_first;   // hold this request until every reply is in
   } slot_cmd_type;

   typedef struct {
      logic                ok;
      logic [ID_W-1:0]     out_id;
      logic [OFFSET_W-1:0] offset;
   } slot_reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;

   bia_req_if req_bus ();
   bia_rsp_if rsp_bus ();

   bitmap_id_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the allocator: bit s of slot_taken belongs to id s+1.
   bit [CAPACITY-1:0] slot_taken = '0;
   logic [ELEM_W-1:0] elem_size  = ELEM_W'(1);
   logic [ID_W-1:0]   id_ceiling = ID_W'(256);

   slot_cmd_type   cmds_pending[$];   // requests not yet presented
   slot_reply_type replies_due[$];    // predicted replies, oldest first

   int mismatch_count  = 0;
   int replies_checked = 0;
   int reqs_accepted   = 0;
   int allocs_seen     = 0;
   int allocs_refused  = 0;
   int csr_writes      = 0;
   bit quiet_tail      = 1'b0;   // no idling on either side once set
   bit req_fire;
   int req_gap;
   int rsp_stall;

   // Clock: 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Effective id limit: the smaller of max_entries and the table size.
   function automatic int id_limit();
      return (int'(id_ceiling) < CAPACITY) ? int'(id_ceiling) : CAPACITY;
   endfunction

   // Byte offset of a slot, kept to the width of the offset field.
   function automatic logic [OFFSET_W-1:0] slot_offset(input logic [ID_W-1:0] id);
      logic [31:0] product;
      product = (32'(id) - 32'd1) * 32'(elem_size);
      return product[OFFSET_W-1:0];
   endfunction

   // Apply one request to the local bitmap and return the reply it must produce.
   function automatic slot_reply_type predict_slot_reply(input logic [1:0] command,
                                                         input logic [ID_W-1:0] id);
      slot_reply_type reply;
      int             limit;
      bit             id_ok;
      reply = '{ok: 1'b0, out_id: '0, offset: '0};
      limit = id_limit();
      id_ok = (int'(id) >= 1) && (int'(id) <= limit);
      case (command)
         CMD_ALLOC: begin
            allocs_seen++;
            // First fit: lowest free slot below the limit.
            for (int s = 0; s < limit; s++) begin
               if (!slot_taken[s]) begin
                  slot_taken[s] = 1'b1;
                  reply.ok      = 1'b1;
                  reply.out_id  = ID_W'(s + 1);
                  reply.offset  = slot_offset(ID_W'(s + 1));
                  break;
               end
            end
            if (!reply.ok) allocs_refused++;
         end
         CMD_RELEASE: begin
            reply.out_id = id;
            // Releasing a free id still counts as accepted.
            if (id_ok) begin
               slot_taken[int'(id) - 1] = 1'b0;
               reply.ok     = 1'b1;
               reply.offset = slot_offset(id);
            end
         end
         CMD_QUERY: begin
            reply.out_id = id;
            if (id_ok && slot_taken[int'(id) - 1]) begin
               reply.ok     = 1'b1;
               reply.offset = slot_offset(id);
            end
         end
         default: begin
            // Unused command: reply stays all zero.
         end
      endcase
      return reply;
   endfunction

   // Monitor: check each reply against the oldest prediction, then record newly
   // accepted requests. Check first so a new request never pairs with an early reply.
   always @(posedge clock) begin
      slot_reply_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            replies_checked++;
            if (replies_due.size() == 0) begin
               $display("%0t: reply with none expected: got ok %0d id %0d offset %0d",
                        $time, rsp_bus.ok, rsp_bus.out_id, rsp_bus.offset);
               mismatch_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_bus.ok !== want.ok || rsp_bus.out_id !== want.out_id ||
                   rsp_bus.offset !== want.offset) begin
                  $display({"%0t: reply mismatch: expected ok %0d id %0d offset %0d,",
                            " got ok %0d id %0d offset %0d"},
                           $time, want.ok, want.out_id, want.offset,
                           rsp_bus.ok, rsp_bus.out_id, rsp_bus.offset);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            reqs_accepted++;
            replies_due.push_back(predict_slot_reply(req_bus.command, req_bus.id));
         end
      end
   end

   // Request driver: change inputs on the falling edge, one assignment per signal.
   always @(negedge clock) begin
      slot_cmd_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
      end else if (req_bus.valid && !req_fire) begin
         // Hold the current request until the block takes it.
      end else if (req_gap > 0) begin
         req_bus.valid <= 1'b0;
         req_gap       <= req_gap - 1;
      end else if (cmds_pending.size() == 0 ||
                   (cmds_pending[0].drain_first && replies_due.size() != 0)) begin
         // Nothing to send, or drain every reply before this request.
         req_bus.valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         // Open a random-length idle burst, this one included.
         req_bus.valid <= 1'b0;
         req_gap       <= $urandom_range(0, 17);
      end else begin
         head            = cmds_pending.pop_front();
         req_bus.valid   <= 1'b1;
         req_bus.command <= head.command;
         req_bus.id      <= head.id;
      end
   end

   // Reply sink: stall in random bursts, never in the tail.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
      end else if (quiet_tail) begin
         rsp_bus.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= rsp_stall - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= $urandom_range(0, 17);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic queue_cmd(input logic [1:0] command, input int id, input bit drain_first = 1'b0);
      cmds_pending.push_back('{command: command, id: ID_W'(id), drain_first: drain_first});
   endtask

   // Pick a release or query id: mostly valid, some zero, some above the limit.
   function automatic int pick_id();
      int limit;
      int roll;
      limit = id_limit();
      roll  = $urandom_range(0, 99);
      if (roll < 8 || limit == 0) return 0;
      if (roll < 25 && limit < ID_MAX) return $urandom_range(limit + 1, ID_MAX);
      return $urandom_range(1, limit);
   endfunction

   // Queue a random mix; alloc carries a random id that the block must ignore.
   task automatic queue_mixed(input int count, input int alloc_pct, input int release_pct);
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct)
            queue_cmd(CMD_ALLOC, $urandom_range(0, ID_MAX), $urandom_range(0, 29) == 0);
         else if (roll < alloc_pct + release_pct)
            queue_cmd(CMD_RELEASE, pick_id(), $urandom_range(0, 29) == 0);
         else
            queue_cmd(CMD_QUERY, pick_id(), $urandom_range(0, 29) == 0);
      end
   endtask

   // Wait until every request is sent and answered, then let the block go idle.
   task automatic settle_idle();
      @(posedge clock);
      #1;
      while (cmds_pending.size() != 0 || req_bus.valid || replies_due.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register while idle and mirror it in the local model.
   task automatic write_csr(input bia_csr_type index, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_ELEM_BYTES) elem_size = ELEM_W'(value);
      else id_ceiling = ID_W'(value);
      csr_writes++;
   endtask

   // Timeout guard, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      // Drive every input to a known value from time zero.
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_ALLOC;
      req_bus.id      = '0;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_ELEM_BYTES;
      csr_wdata       = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: fill ids 1 to 5, probe free, used, zero and top ids.
      repeat (5) queue_cmd(CMD_ALLOC, 0);
      queue_cmd(CMD_QUERY, 2);
      queue_cmd(CMD_QUERY, 6);
      queue_cmd(CMD_QUERY, 0);
      queue_cmd(CMD_QUERY, 256);
      queue_cmd(CMD_RELEASE, 0);
      queue_cmd(CMD_RELEASE, 2);
      queue_cmd(CMD_RELEASE, 200);          // free id: accepted, bit stays clear
      queue_cmd(CMD_ALLOC, 256);            // refills the hole at id 2
      queue_cmd(CMD_UNUSED, 256);
      settle_idle();

      // Largest element, limit 3: table full, used slot above the limit unreachable.
      write_csr(CSR_ELEM_BYTES, 65535);
      write_csr(CSR_MAX_ENTRIES, 3);
      queue_cmd(CMD_ALLOC, 0);
      queue_cmd(CMD_QUERY, 3);
      queue_cmd(CMD_QUERY, 4);
      queue_cmd(CMD_RELEASE, 256);
      queue_cmd(CMD_RELEASE, 3);
      queue_cmd(CMD_ALLOC, 0);
      settle_idle();

      // Limit of zero: nothing is valid and nothing can be allocated.
      write_csr(CSR_MAX_ENTRIES, 0);
      queue_cmd(CMD_ALLOC, 0);
      queue_cmd(CMD_QUERY, 1);
      settle_idle();

      // Smallest element and limit of one.
      write_csr(CSR_ELEM_BYTES, 1);
      write_csr(CSR_MAX_ENTRIES, 1);
      queue_cmd(CMD_ALLOC, 0);
      queue_cmd(CMD_QUERY, 1);
      settle_idle();

      // Raise the limit back: id 4 kept its bit while out of reach.
      write_csr(CSR_ELEM_BYTES, 65535);
      write_csr(CSR_MAX_ENTRIES, 256);
      queue_cmd(CMD_QUERY, 4);
      queue_cmd(CMD_QUERY, 256);
      settle_idle();

      // Random mix on a small table.
      write_csr(CSR_ELEM_BYTES, $urandom_range(1, 65535));
      write_csr(CSR_MAX_ENTRIES, $urandom_range(2, 40));
      queue_mixed(60, 45, 30);
      settle_idle();

      // Fill the whole table at the largest element size so scans run to the top
      // group and the last allocations fail on a full table.
      write_csr(CSR_ELEM_BYTES, 65535);
      write_csr(CSR_MAX_ENTRIES, 256);
      for (int n = 0; n < 260; n++) begin
         queue_cmd(CMD_ALLOC, $urandom_range(0, ID_MAX));
         if (n % 20 == 19) queue_cmd(CMD_QUERY, pick_id());
      end
      settle_idle();

      // Carve holes with heavy release traffic; the first request waits for a drain.
      write_csr(CSR_ELEM_BYTES, $urandom_range(1, 65535));
      write_csr(CSR_MAX_ENTRIES, $urandom_range(100, 256));
      queue_cmd(CMD_QUERY, pick_id(), 1'b1);
      queue_mixed(79, 30, 45);
      settle_idle();

      // Tail at full rate: no idling on either side.
      write_csr(CSR_ELEM_BYTES, $urandom_range(1, 65535));
      write_csr(CSR_MAX_ENTRIES, 256);
      quiet_tail = 1'b1;
      queue_mixed(40, 40, 30);
      settle_idle();

      $display("covered %0d requests: %0d allocations, %0d refused for lack of a free slot",
               reqs_accepted, allocs_seen, allocs_refused);
      $display("checked %0d replies across %0d register writes", replies_checked, csr_writes);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
